>>> hdl/u8u16_pkg.sv
// shared types and constants of the utf-8 to utf-16 transcoder
`timescale 1ns / 1ps

package u8u16_pkg;

	// status codes carried on the terminator result
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// configuration register indexes
	localparam logic REG_BUFFER_UNITS = 1'b0;
	localparam logic REG_COUNT_ONLY   = 1'b1;

	localparam logic [15:0] BUFFER_UNITS_RESET = 16'd256;

	localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
	localparam logic [20:0] CP_MAX       = 21'h10FFFF;
	localparam logic [15:0] SURR_HI_BASE = 16'hD800;
	localparam logic [15:0] SURR_LO_BASE = 16'hDC00;

	localparam int RES_FIFO_DEPTH = 4;

	typedef struct packed {
		logic [20:0] partial;
		logic [1:0]  pending;
		logic [15:0] units;
		logic        halted;
		logic [1:0]  cause;
	} dec_state_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        end_of_string;
		logic        last_for_byte;
		logic [15:0] unit_count;
		logic [1:0]  status;
	} res_t;

	typedef struct packed {
		logic [1:0] count;
		res_t       first;
		res_t       second;
	} dec_out_t;

endpackage

>>> hdl/utf8_to_utf16_transcoder_unit.sv
// top level of the utf-8 to utf-16 transcoder
`timescale 1ns / 1ps

// channel  direction  handshake            payload
// in       sink       in_valid/in_stall    data_byte
// out      source     out_valid/out_stall  code_unit end_of_string last_for_byte
//                                          unit_count status
// cfg      sink       cfg_valid/cfg_ready  cfg_index cfg_data
//
// one byte is taken per cycle while in_stall is low; its results enter
// the queue at that edge and are offered from the next cycle
// a surrogate pair leaves as two units, one per cycle while out_stall is low
// in_stall rises only when the result queue lacks room for two more results
// reset clears the string state and the queue; buffer_units returns to 256

module utf8_to_utf16_transcoder_unit import u8u16_pkg::*; #(
	parameter int FIFO_DEPTH = RES_FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] code_unit,
	output logic        end_of_string,
	output logic        last_for_byte,
	output logic [15:0] unit_count,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] buffer_units_q;
	logic        count_only_q;
	dec_state_t  state_q;
	dec_state_t  state_next;
	dec_out_t    dec_res;
	logic        in_take;
	logic        room_for_two;
	res_t        head;
	logic [1:0]  push_count;

	assign cfg_ready = 1'b1;
	assign in_stall  = !room_for_two;
	assign in_take   = in_valid && room_for_two;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_units_q <= BUFFER_UNITS_RESET;
			count_only_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BUFFER_UNITS: buffer_units_q <= cfg_data;
				REG_COUNT_ONLY:   count_only_q   <= cfg_data[0];
				default:          buffer_units_q <= buffer_units_q;
			endcase
		end
	end

	u8u16_decode u_decode (
		.data_byte    (data_byte),
		.st           (state_q),
		.buffer_units (buffer_units_q),
		.count_only   (count_only_q),
		.nxt          (state_next),
		.res          (dec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (in_take) begin
			state_q <= state_next;
		end
	end

	assign push_count = in_take ? dec_res.count : 2'd0;

	u8u16_res_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_res_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_count   (push_count),
		.push_first   (dec_res.first),
		.push_second  (dec_res.second),
		.pop          (!out_stall),
		.head_valid   (out_valid),
		.head         (head),
		.room_for_two (room_for_two)
	);

	assign code_unit     = head.code_unit;
	assign end_of_string = head.end_of_string;
	assign last_for_byte = head.last_for_byte;
	assign unit_count    = head.unit_count;
	assign status        = head.status;

	// second half of a surrogate pair is already queued behind the first
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_for_byte) |=> out_valid)
		else $error("low surrogate missing after high surrogate");

	// a terminator item always leaves a result behind
	a_term_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && data_byte == 8'h00) |=> out_valid)
		else $error("no result queued for terminator item");

	// halt status only ever rides on the terminator result
	a_status_eos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (end_of_string && last_for_byte))
		else $error("nonzero status on a unit result");

endmodule

>>> hdl/u8u16_decode.sv
// byte decoder: next string state and up to two results for one input byte
`timescale 1ns / 1ps

module u8u16_decode import u8u16_pkg::*; (
	input  logic [7:0]  data_byte,
	input  dec_state_t  st,
	input  logic [15:0] buffer_units,
	input  logic        count_only,
	output dec_state_t  nxt,
	output dec_out_t    res
);

	logic        emit_go;
	logic        stop_go;
	logic [1:0]  stop_cause;
	logic [20:0] cp;
	logic [20:0] gathered;
	logic [20:0] v_full;
	logic        need_pair;
	logic [15:0] u1;
	logic [15:0] u2;
	logic [16:0] need_total;

	// saturating unit counts after one and two more units
	assign u1 = (st.units == 16'hFFFF) ? st.units : st.units + 16'd1;
	assign u2 = (u1 == 16'hFFFF) ? u1 : u1 + 16'd1;

	assign gathered = {st.partial[14:0], data_byte[5:0]};

	always_comb begin
		nxt        = st;
		res        = '0;
		emit_go    = 1'b0;
		stop_go    = 1'b0;
		stop_cause = ST_OK;
		cp         = '0;

		if (data_byte == 8'h00) begin
			// terminator: a sequence left open counts as a bad continuation
			res.count                = 2'd1;
			res.first.end_of_string  = 1'b1;
			res.first.last_for_byte  = 1'b1;
			res.first.unit_count     = st.units;
			if (st.halted) begin
				res.first.status = st.cause;
			end else if (st.pending != 2'd0) begin
				res.first.status = ST_INVALID;
			end else begin
				res.first.status = ST_OK;
			end
			nxt = '0;
		end else if (!st.halted) begin
			if (st.pending != 2'd0) begin
				if (data_byte[7:6] != 2'b10) begin
					stop_go    = 1'b1;
					stop_cause = ST_INVALID;
				end else begin
					nxt.pending = st.pending - 2'd1;
					if (st.pending == 2'd1) begin
						emit_go     = 1'b1;
						cp          = gathered;
						nxt.partial = '0;
					end else begin
						nxt.partial = gathered;
					end
				end
			end else if (!data_byte[7]) begin
				emit_go = 1'b1;
				cp      = {13'd0, data_byte};
			end else if (data_byte[7:5] == 3'b110) begin
				nxt.partial = {16'd0, data_byte[4:0]};
				nxt.pending = 2'd1;
			end else if (data_byte[7:4] == 4'b1110) begin
				nxt.partial = {17'd0, data_byte[3:0]};
				nxt.pending = 2'd2;
			end else if (data_byte[7:3] == 5'b11110) begin
				nxt.partial = {18'd0, data_byte[2:0]};
				nxt.pending = 2'd3;
			end else begin
				stop_go    = 1'b1;
				stop_cause = ST_INVALID;
			end
		end

		need_pair  = (cp >= CP_SUPP_BASE);
		v_full     = cp - CP_SUPP_BASE;
		need_total = {1'b0, st.units} + (need_pair ? 17'd2 : 17'd1);

		if (emit_go) begin
			if (cp > CP_MAX) begin
				stop_go    = 1'b1;
				stop_cause = ST_INVALID;
			end else if (count_only) begin
				nxt.units = need_pair ? u2 : u1;
			end else if (need_total >= {1'b0, buffer_units}) begin
				// one unit stays free for the terminator
				stop_go    = 1'b1;
				stop_cause = ST_FULL;
			end else if (!need_pair) begin
				res.count                = 2'd1;
				res.first.code_unit      = cp[15:0];
				res.first.last_for_byte  = 1'b1;
				res.first.unit_count     = u1;
				res.first.status         = ST_OK;
				nxt.units                = u1;
			end else begin
				res.count                = 2'd2;
				res.first.code_unit      = SURR_HI_BASE | {6'd0, v_full[19:10]};
				res.first.unit_count     = u1;
				res.first.status         = ST_OK;
				res.second.code_unit     = SURR_LO_BASE | {6'd0, v_full[9:0]};
				res.second.last_for_byte = 1'b1;
				res.second.unit_count    = u2;
				res.second.status        = ST_OK;
				nxt.units                = u2;
			end
		end

		if (stop_go) begin
			nxt.halted  = 1'b1;
			nxt.cause   = stop_cause;
			nxt.pending = 2'd0;
			nxt.partial = '0;
		end
	end

endmodule

>>> hdl/u8u16_res_fifo.sv
// result queue: takes up to two results a cycle, hands out one when popped
`timescale 1ns / 1ps

module u8u16_res_fifo import u8u16_pkg::*; #(
	parameter int DEPTH = RES_FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_count,
	input  res_t       push_first,
	input  res_t       push_second,
	input  logic       pop,
	output logic       head_valid,
	output res_t       head,
	output logic       room_for_two
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] TWO_BELOW = CW'(DEPTH - 2);

	res_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] wr_ptr_p1;
	logic [PW-1:0] wr_ptr_p2;
	logic          do_pop;

	function automatic logic [PW-1:0] step_ptr(input logic [PW-1:0] p);
		step_ptr = (p == LAST_PTR) ? '0 : p + PW'(1);
	endfunction

	assign wr_ptr_p1    = step_ptr(wr_ptr_q);
	assign wr_ptr_p2    = step_ptr(wr_ptr_p1);
	assign head_valid   = (count_q != '0);
	assign head         = mem_q[rd_ptr_q];
	assign do_pop       = pop && head_valid;
	assign room_for_two = (count_q <= TWO_BELOW);

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			mem_q[wr_ptr_q] <= push_first;
		end
		if (push_count == 2'd2) begin
			mem_q[wr_ptr_p1] <= push_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_count == 2'd1) begin
				wr_ptr_q <= wr_ptr_p1;
			end else if (push_count == 2'd2) begin
				wr_ptr_q <= wr_ptr_p2;
			end
			if (do_pop) begin
				rd_ptr_q <= step_ptr(rd_ptr_q);
			end
			count_q <= count_q + CW'(push_count) - CW'(do_pop);
		end
	end

endmodule
